// ===== rtl/linear_probe_hash_table_assert.svh =====
// assertion macros shared by the hash table checks
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// same-cycle implication, sampled on aclk, quiet while aresetn is low
`define LPHT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lpht check failed");

// next-cycle implication, sampled on aclk, quiet while aresetn is low
`define LPHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lpht check failed");

`endif

// ===== rtl/lpht_pkg.sv =====
// shared constants, codes and types of the linear probing hash table
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int unsigned TABLE_SLOTS = 4096;
    localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int unsigned CNT_W       = SLOT_W + 1;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned KEY_W      = 32;
    localparam int unsigned VAL_W      = 8;
    localparam int unsigned IDX_W      = 12;
    localparam int unsigned STAT_W     = 2;
    localparam int unsigned USED_W     = 12;
    localparam int unsigned ITEM_CNT_W = 13;

    // input transfer layout
    localparam int unsigned O_OP      = 0;
    localparam int unsigned O_KEY     = O_OP + OP_W;
    localparam int unsigned O_VAL     = O_KEY + KEY_W;
    localparam int unsigned O_IDX     = O_VAL + VAL_W;
    localparam int unsigned S_TDATA_W = ((O_IDX + IDX_W + 7) / 8) * 8;

    // result transfer layout
    localparam int unsigned O_STATUS  = 0;
    localparam int unsigned O_USED    = O_STATUS + STAT_W;
    localparam int unsigned O_VALID   = O_USED + USED_W;
    localparam int unsigned O_KEY_OUT = O_VALID + 1;
    localparam int unsigned O_VAL_OUT = O_KEY_OUT + KEY_W;
    localparam int unsigned O_COUNT   = O_VAL_OUT + VAL_W;
    localparam int unsigned M_TDATA_W = ((O_COUNT + ITEM_CNT_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [KEY_W-1:0] HASH_MUL1 = 32'h7feb352d;
    localparam logic [KEY_W-1:0] HASH_MUL2 = 32'h846ca68b;
    localparam int unsigned HASH_SH_A = 16;
    localparam int unsigned HASH_SH_B = 15;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] value;
        logic [KEY_W-1:0] key;
    } slot_entry_t;

    localparam int unsigned ENTRY_W = $bits(slot_entry_t);

endpackage

// ===== rtl/lpht_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module lpht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// top level of the linear probing hash table
`timescale 1ns / 1ps

// channel  dir  payload
// s_*      in   opcode, key_bits, entry_value, slot_index
// m_*      out  status, slot_used, slot_valid, key_out, value_out, item_count
//
// insert and delete: accept, the hash rounds on the shared multiplier (S_MUL1, S_MUL2),
// then S_HOME, then a probe of slots through the single ram read port, then S_FINISH to
// hand the result over; a miss on a full or keyless table probes all 4096 slots.
// read: accept, S_READ, S_FINISH; no-op: accept, S_FINISH. one operation at a time.
// after reset a clearing pass writes every slot empty, with s_tready low.
// a result held by m_tready low does not stop the next input from being taken.

module linear_probe_hash_table (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // opcode, key_bits, entry_value, slot_index
    input  logic [lpht_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status, slot_used, slot_valid, key_out, value_out, item_count
    output logic [lpht_pkg::M_TDATA_W-1:0]   m_tdata
);

    import lpht_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MUL1   = 3'd2;
    localparam logic [2:0] S_MUL2   = 3'd3;
    localparam logic [2:0] S_HOME   = 3'd4;
    localparam logic [2:0] S_PROBE  = 3'd5;
    localparam logic [2:0] S_READ   = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0]           state_reg;
    logic [SLOT_W-1:0]    clr_addr_reg;
    logic [OP_W-1:0]      op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [KEY_W-1:0]     hash_reg;
    logic [KEY_W-1:0]     prod_reg;
    logic [SLOT_W-1:0]    probe_addr_reg;
    logic [CNT_W-1:0]     issue_cnt_reg;
    logic                 chk_vld_reg;
    logic [SLOT_W-1:0]    chk_addr_reg;
    logic                 chk_last_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [STAT_W-1:0]    res_status_reg;
    logic [SLOT_W-1:0]    res_used_reg;
    logic                 res_valid_reg;
    logic [KEY_W-1:0]     res_key_reg;
    logic [VAL_W-1:0]     res_val_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    logic [OP_W-1:0]      in_op;
    logic [KEY_W-1:0]     in_key;
    logic [VAL_W-1:0]     in_val;
    logic [IDX_W-1:0]     in_idx;

    logic [KEY_W-1:0]     mul_a;
    logic [KEY_W-1:0]     mul_b;
    logic [KEY_W-1:0]     mul_full;
    logic [KEY_W-1:0]     mix_b;
    logic [KEY_W-1:0]     mix_c;
    logic [SLOT_W-1:0]    home_slot;

    logic                 rd_en;
    logic [SLOT_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]   rd_word;
    slot_entry_t          rd_entry;
    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_addr;
    slot_entry_t          wr_entry;

    logic                 hit;
    logic                 miss_end;

    assign in_op  = s_tdata[O_OP  +: OP_W];
    assign in_key = s_tdata[O_KEY +: KEY_W];
    assign in_val = s_tdata[O_VAL +: VAL_W];
    assign in_idx = s_tdata[O_IDX +: IDX_W];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // one multiplier serves both rounds of the hash, only the low word is kept
    assign mix_b    = prod_reg ^ (prod_reg >> HASH_SH_B);
    assign mul_a    = (state_reg == S_MUL1) ? hash_reg : mix_b;
    assign mul_b    = (state_reg == S_MUL1) ? HASH_MUL1 : HASH_MUL2;
    assign mul_full = mul_a * mul_b;
    assign mix_c    = prod_reg ^ (prod_reg >> HASH_SH_A);
    assign home_slot = mix_c[SLOT_W-1:0];

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = probe_addr_reg;
        if (state_reg == S_IDLE && s_tvalid) begin
            rd_en   = 1'b1;
            rd_addr = in_idx[SLOT_W-1:0];
        end else if (state_reg == S_PROBE && issue_cnt_reg < CNT_W'(TABLE_SLOTS)) begin
            rd_en   = 1'b1;
        end
    end

    assign rd_entry = slot_entry_t'(rd_word);

    // check the slot read in the previous probe cycle
    assign hit = chk_vld_reg && ((op_reg == OP_INSERT) ? !rd_entry.valid
                 : (rd_entry.valid && rd_entry.key == key_reg));
    assign miss_end = chk_vld_reg && !hit && chk_last_reg;

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = chk_addr_reg;
        wr_entry = '0;
        if (state_reg == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
        end else if (state_reg == S_PROBE && hit) begin
            wr_en = 1'b1;
            if (op_reg == OP_INSERT) begin
                wr_entry.valid = 1'b1;
                wr_entry.value = val_reg;
                wr_entry.key   = key_reg;
            end
        end
    end

    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_lpht_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[O_STATUS  +: STAT_W]     = res_status_reg;
        m_tdata_next[O_USED    +: USED_W]     = USED_W'(res_used_reg);
        m_tdata_next[O_VALID]                 = res_valid_reg;
        m_tdata_next[O_KEY_OUT +: KEY_W]      = res_key_reg;
        m_tdata_next[O_VAL_OUT +: VAL_W]      = res_val_reg;
        m_tdata_next[O_COUNT   +: ITEM_CNT_W] = ITEM_CNT_W'(count_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            chk_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // in S_FINISH the handover below decides m_tvalid_reg
            if (m_tvalid_reg && m_tready && state_reg != S_FINISH) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == SLOT_W'(TABLE_SLOTS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg         <= in_op;
                        key_reg        <= in_key;
                        val_reg        <= in_val;
                        hash_reg       <= in_key ^ (in_key >> HASH_SH_A);
                        res_status_reg <= ST_OK;
                        res_used_reg   <= (in_op == OP_READ) ? in_idx[SLOT_W-1:0] : '0;
                        res_valid_reg  <= 1'b0;
                        res_key_reg    <= '0;
                        res_val_reg    <= '0;
                        unique case (in_op) inside
                            OP_INSERT, OP_DELETE: state_reg <= S_MUL1;
                            OP_READ: state_reg <= S_READ;
                            default: state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_MUL1: begin
                    prod_reg  <= mul_full;
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    prod_reg  <= mul_full;
                    state_reg <= S_HOME;
                end
                S_HOME: begin
                    probe_addr_reg <= home_slot;
                    issue_cnt_reg  <= '0;
                    chk_vld_reg    <= 1'b0;
                    state_reg      <= S_PROBE;
                end
                S_PROBE: begin
                    // reads run one slot ahead of the check
                    chk_vld_reg <= rd_en && !hit && !miss_end;
                    if (rd_en) begin
                        probe_addr_reg <= probe_addr_reg + 1'b1;
                        issue_cnt_reg  <= issue_cnt_reg + 1'b1;
                        chk_addr_reg   <= probe_addr_reg;
                        chk_last_reg   <= (issue_cnt_reg == CNT_W'(TABLE_SLOTS - 1));
                    end
                    if (hit) begin
                        res_used_reg <= chk_addr_reg;
                        if (op_reg == OP_INSERT) begin
                            count_reg <= count_reg + 1'b1;
                        end else begin
                            count_reg <= count_reg - 1'b1;
                        end
                        state_reg <= S_FINISH;
                    end else if (miss_end) begin
                        res_status_reg <= (op_reg == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                        state_reg      <= S_FINISH;
                    end
                end
                S_READ: begin
                    res_valid_reg <= rd_entry.valid;
                    res_key_reg   <= rd_entry.valid ? rd_entry.key : '0;
                    res_val_reg   <= rd_entry.valid ? rd_entry.value : '0;
                    state_reg     <= S_FINISH;
                end
                S_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= m_tdata_next;
                        state_reg    <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/lpht_checker.sv =====
// port level checks of the hash table and their bind
`timescale 1ns / 1ps

`include "linear_probe_hash_table_assert.svh"

module lpht_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [lpht_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lpht_pkg::M_TDATA_W-1:0] m_tdata
);

    import lpht_pkg::*;

    logic [STAT_W-1:0]     out_status;
    logic [USED_W-1:0]     out_used;
    logic                  out_valid;
    logic [KEY_W-1:0]      out_key;
    logic [VAL_W-1:0]      out_val;
    logic [ITEM_CNT_W-1:0] out_count;
    logic                  in_xfer;

    assign out_status = m_tdata[O_STATUS  +: STAT_W];
    assign out_used   = m_tdata[O_USED    +: USED_W];
    assign out_valid  = m_tdata[O_VALID];
    assign out_key    = m_tdata[O_KEY_OUT +: KEY_W];
    assign out_val    = m_tdata[O_VAL_OUT +: VAL_W];
    assign out_count  = m_tdata[O_COUNT   +: ITEM_CNT_W];
    assign in_xfer    = s_tvalid && s_tready && (s_tdata[O_OP +: OP_W] != OP_NOP);

    // a held result stays put until its transfer
    `LPHT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a failed insert or delete names no slot and shows no contents
    `LPHT_ASSERT_IMP(a_fail_clean, m_tvalid && out_status != ST_OK,
        out_used == '0 && !out_valid && out_key == '0 && out_val == '0)

    // an empty slot never leaks old contents
    `LPHT_ASSERT_IMP(a_empty_clean, m_tvalid && !out_valid, out_key == '0 && out_val == '0)

    // the occupancy cannot pass the table size
    `LPHT_ASSERT_IMP(a_count_bound, m_tvalid, out_count <= ITEM_CNT_W'(TABLE_SLOTS))

    // a real operation moves the block out of S_IDLE, so it is never taken twice in a row
    `LPHT_ASSERT_NEXT(a_no_back_to_back, in_xfer, !s_tready)

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

// ===== sim/linear_probe_hash_table_test.sv =====
// self-checking testbench for the linear probing hash table
`timescale 1ns / 1ps

module linear_probe_hash_table_test;
    import lpht_pkg::*;

    localparam int unsigned IDLE_LIMIT = 20000;  // cycles without any transfer
    localparam int unsigned TAIL_WAIT  = 4200;   // one full-table probe and then some

    typedef struct {
        logic [OP_W-1:0]  opcode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] idx;
    } table_op_t;

    typedef struct {
        logic [STAT_W-1:0]     status;
        logic [USED_W-1:0]     slot;
        logic                  valid;
        logic [KEY_W-1:0]      key;
        logic [VAL_W-1:0]      value;
        logic [ITEM_CNT_W-1:0] count;
    } table_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    linear_probe_hash_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow of the table contents
    bit [KEY_W-1:0] shadow_keys  [TABLE_SLOTS];
    bit [VAL_W-1:0] shadow_vals  [TABLE_SLOTS];
    bit             shadow_used  [TABLE_SLOTS];
    int unsigned    shadow_count = 0;

    table_op_t        op_queue[$];
    table_result_t    expected_results[$];
    logic [KEY_W-1:0] live_keys[$];     // keys present once every queued op has run
    table_op_t        drv_op;

    int unsigned n_issued = 0, n_accepted = 0, n_errors = 0, idle_cycles = 0;
    int unsigned n_insert = 0, n_full = 0, n_delete = 0, n_absent = 0;
    int unsigned n_read = 0, n_read_hit = 0, n_nop = 0, peak_count = 0;
    int unsigned send_idle_pct = 0, stall_pct = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic logic [SLOT_W-1:0] home_of(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] h;
        h = k;
        h = h ^ (h >> HASH_SH_A);
        h = h * HASH_MUL1;
        h = h ^ (h >> HASH_SH_B);
        h = h * HASH_MUL2;
        h = h ^ (h >> HASH_SH_A);
        return h[SLOT_W-1:0];
    endfunction

    // runs one operation on the shadow table and gives the result it must produce
    function automatic table_result_t apply_table_op(table_op_t op);
        table_result_t r;
        int unsigned   s, n;
        bit            done;
        r = '{default: '0};
        done = 1'b0;
        case (op.opcode)
            OP_INSERT: begin
                n_insert++;
                r.status = ST_FULL;
                for (n = 0; n < TABLE_SLOTS && !done; n++) begin
                    s = (home_of(op.key) + n) & (TABLE_SLOTS - 1);
                    if (!shadow_used[s]) begin
                        shadow_keys[s] = op.key;
                        shadow_vals[s] = op.value;
                        shadow_used[s] = 1'b1;
                        shadow_count++;
                        r.status = ST_OK;
                        r.slot   = USED_W'(s);
                        done     = 1'b1;
                    end
                end
                if (!done) n_full++;
            end
            OP_DELETE: begin
                n_delete++;
                r.status = ST_NOT_FOUND;
                // the whole ring is walked, so cleared slots never hide a key
                for (n = 0; n < TABLE_SLOTS && !done; n++) begin
                    s = (home_of(op.key) + n) & (TABLE_SLOTS - 1);
                    if (shadow_used[s] && shadow_keys[s] == op.key) begin
                        shadow_used[s] = 1'b0;
                        if (shadow_count > 0) shadow_count--;
                        r.status = ST_OK;
                        r.slot   = USED_W'(s);
                        done     = 1'b1;
                    end
                end
                if (!done) n_absent++;
            end
            OP_READ: begin
                n_read++;
                s      = op.idx & (TABLE_SLOTS - 1);
                r.slot = USED_W'(s);
                if (shadow_used[s]) begin
                    n_read_hit++;
                    r.valid = 1'b1;
                    r.key   = shadow_keys[s];
                    r.value = shadow_vals[s];
                end
            end
            default: begin
                n_nop++;
            end
        endcase
        r.count = ITEM_CNT_W'(shadow_count);
        if (shadow_count > peak_count) peak_count = shadow_count;
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_op(table_op_t op);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[O_OP  +: OP_W]  = op.opcode;
        d[O_KEY +: KEY_W] = op.key;
        d[O_VAL +: VAL_W] = op.value;
        d[O_IDX +: IDX_W] = op.idx;
        return d;
    endfunction

    function automatic table_result_t unpack_result(logic [M_TDATA_W-1:0] d);
        table_result_t r;
        r.status = d[O_STATUS  +: STAT_W];
        r.slot   = d[O_USED    +: USED_W];
        r.valid  = d[O_VALID];
        r.key    = d[O_KEY_OUT +: KEY_W];
        r.value  = d[O_VAL_OUT +: VAL_W];
        r.count  = d[O_COUNT   +: ITEM_CNT_W];
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] key_for_home(logic [SLOT_W-1:0] target);
        logic [KEY_W-1:0] k;
        k = $urandom;
        while (home_of(k) != target) k = $urandom;
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] pick_live_key();
        return live_keys[$urandom_range(live_keys.size() - 1)];
    endfunction

    function automatic logic [VAL_W-1:0] rand_val();
        return VAL_W'($urandom_range(255));
    endfunction

    function automatic logic [IDX_W-1:0] rand_idx();
        return IDX_W'($urandom_range(4095));
    endfunction

    task automatic queue_op(input logic [OP_W-1:0] opc, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] value, input logic [IDX_W-1:0] idx);
        table_op_t op;
        int        i;
        bit        hit;
        op.opcode = opc;
        op.key    = key;
        op.value  = value;
        op.idx    = idx;
        op_queue.push_back(op);
        n_issued++;
        hit = 1'b0;
        if (opc == OP_INSERT && live_keys.size() < TABLE_SLOTS) begin
            live_keys.push_back(key);
        end else if (opc == OP_DELETE) begin
            for (i = 0; i < live_keys.size() && !hit; i++) begin
                if (live_keys[i] == key) begin
                    live_keys.delete(i);
                    hit = 1'b1;
                end
            end
        end
    endtask

    task automatic queue_random_op();
        int               pick;
        logic [KEY_W-1:0] k;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(99);
        if (pick < 50 || (pick < 70 && live_keys.size() == 0)) begin
            // some inserts repeat a live key so duplicates sit side by side
            if (live_keys.size() > 0 && $urandom_range(9) == 0) k = pick_live_key();
            else k = $urandom;
            queue_op(OP_INSERT, k, rand_val(), rand_idx());
        end else if (pick < 70) begin
            queue_op(OP_DELETE, pick_live_key(), rand_val(), rand_idx());
        end else if (pick < 73) begin
            queue_op(OP_DELETE, $urandom, rand_val(), rand_idx());
        end else if (pick < 95) begin
            if (live_keys.size() > 0 && $urandom_range(1) == 1)
                idx = home_of(pick_live_key()) + IDX_W'($urandom_range(3));
            else
                idx = rand_idx();
            queue_op(OP_READ, $urandom, rand_val(), idx);
        end else begin
            queue_op(OP_NOP, $urandom, rand_val(), rand_idx());
        end
    endtask

    task automatic wait_drained();
        while (n_accepted != n_issued || expected_results.size() != 0) @(negedge aclk);
    endtask

    task automatic compare_field(input string name, input logic [KEY_W-1:0] want,
                                 input logic [KEY_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_table_op(drv_op));
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (op_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_op = op_queue.pop_front();
                    s_tdata  <= pack_op(drv_op);
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        table_result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = unpack_result(m_tdata);
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result transfer, expected none, got 0x%0h",
                             $time, m_tdata);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status",     KEY_W'(want.status), KEY_W'(got.status));
                    compare_field("slot_used",  KEY_W'(want.slot),   KEY_W'(got.slot));
                    compare_field("slot_valid", KEY_W'(want.valid),  KEY_W'(got.valid));
                    compare_field("key_out",    want.key,            got.key);
                    compare_field("value_out",  KEY_W'(want.value),  KEY_W'(got.value));
                    compare_field("item_count", KEY_W'(want.count),  KEY_W'(got.count));
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [KEY_W-1:0]  k_top, k_col;
        logic [SLOT_W-1:0] h_ones;
        int                ph, i;
        int unsigned       idle_by_phase  [4];
        int unsigned       stall_by_phase [4];

        idle_by_phase  = '{0, 78, 0, 14};
        stall_by_phase = '{0, 0, 78, 14};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, duplicates, wrap past the last slot, gaps left by deletes
        h_ones = home_of(32'hFFFF_FFFF);
        k_top  = key_for_home(SLOT_W'(TABLE_SLOTS - 1));
        k_col  = key_for_home(h_ones);
        queue_op(OP_INSERT, 32'h0000_0000, 8'h00, 12'h000);
        queue_op(OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 12'hFFF);
        queue_op(OP_INSERT, 32'h8000_0000, 8'h5A, 12'h000);   // negative zero is its own key
        queue_op(OP_INSERT, 32'h0000_0000, 8'hA5, 12'hFFF);
        queue_op(OP_INSERT, k_top, 8'h11, 12'h000);
        queue_op(OP_INSERT, k_top, 8'h22, 12'h000);           // wraps to the bottom
        queue_op(OP_READ, 32'hFFFF_FFFF, 8'hFF, home_of(32'h0));
        queue_op(OP_READ, 32'h0, 8'h00, home_of(32'h0) + 1'b1);
        queue_op(OP_READ, 32'h0, 8'h00, 12'hFFF);
        queue_op(OP_READ, 32'h0, 8'h00, 12'h000);
        queue_op(OP_DELETE, 32'h0000_0000, 8'h00, 12'h000);
        queue_op(OP_READ, 32'h0, 8'h00, home_of(32'h0));      // cleared slot reads as zeros
        queue_op(OP_DELETE, 32'h0000_0000, 8'h00, 12'h000);
        queue_op(OP_DELETE, 32'h0000_0000, 8'h00, 12'h000);   // none left
        queue_op(OP_DELETE, k_top, 8'h00, 12'h000);
        queue_op(OP_DELETE, k_top, 8'h00, 12'h000);
        queue_op(OP_DELETE, 32'h7FC0_0000, 8'h00, 12'h000);   // quiet nan never stored
        queue_op(OP_NOP, 32'hFFFF_FFFF, 8'hFF, 12'hFFF);
        queue_op(OP_NOP, 32'h0, 8'h00, 12'h000);
        queue_op(OP_INSERT, k_col, 8'h3C, 12'h000);
        queue_op(OP_DELETE, 32'hFFFF_FFFF, 8'h00, 12'h000);
        queue_op(OP_DELETE, k_col, 8'h00, 12'h000);           // must look past the hole
        queue_op(OP_READ, 32'h0, 8'h00, h_ones + 1'b1);
        wait_drained();

        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_by_phase[ph];
            stall_pct     = stall_by_phase[ph];
            for (i = 0; i < 420; i++) queue_random_op();
            wait_drained();
        end

        // mostly deletes of stored keys, mixed with reads
        send_idle_pct = 14;
        stall_pct     = 14;
        for (i = 0; i < 250; i++) begin
            if ($urandom_range(9) < 7 && live_keys.size() > 0)
                queue_op(OP_DELETE, pick_live_key(), rand_val(), rand_idx());
            else
                queue_op(OP_READ, $urandom, rand_val(), rand_idx());
        end
        wait_drained();

        repeat (TAIL_WAIT) @(posedge aclk);

        $display("%0d operations: %0d inserts (%0d refused, table full), %0d deletes (%0d absent)",
                 n_accepted, n_insert, n_full, n_delete, n_absent);
        $display("%0d slot reads (%0d occupied), %0d no-ops, peak occupancy %0d of %0d slots",
                 n_read, n_read_hit, n_nop, peak_count, TABLE_SLOTS);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
